// ----- src/assert_macros.svh -----
// Assertion helpers for the wave speed estimator.
// Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHECK_IMPLY(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication.
`define CHECK_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- src/hwse_pkg.sv -----
// ----------------------------------------------------------------------------
// hwse_pkg
// Types, constants and saturation helper for the HLLE wave speed estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package hwse_pkg;

    localparam int GAMMA_W = 19;
    localparam logic [GAMMA_W-1:0] GAMMA_RESET = 19'd91750;
    localparam int Q_ONE = 65536;

    // quotient bits produced by the restoring divider, and its latency
    localparam int QUOT_W = 31;
    localparam int DIV_LAT = QUOT_W + 2;

    // numerator widths: momentum in Q16.32 form, gamma times pressure
    localparam int VEL_NUM_W = 48;
    localparam int SND_NUM_W = 52;

    // square root of a 31-bit value shifted left by 16
    localparam int ROOT_W = 24;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] rho_left;
        logic signed [31:0] mom_x_left;
        logic signed [31:0] mom_y_left;
        logic signed [31:0] mom_z_left;
        logic signed [31:0] energy_left;
        logic signed [31:0] rho_right;
        logic signed [31:0] mom_x_right;
        logic signed [31:0] mom_y_right;
        logic signed [31:0] mom_z_right;
        logic signed [31:0] energy_right;
    } face_t;

    typedef struct packed {
        logic signed [31:0] speed_min;
        logic signed [31:0] speed_max;
        logic               density_fault;
    } wave_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'(S32_MAX)) begin
            r = S32_MAX;
        end
        else if (v < 64'(S32_MIN)) begin
            r = S32_MIN;
        end
        else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/hlle_wave_speed_estimate.sv -----
// ----------------------------------------------------------------------------
// hlle_wave_speed_estimate
// HLLE minimum and maximum signal speeds for 3-D Euler face states, Q16.16.
// ----------------------------------------------------------------------------
//  channel | dir | handshake               | payload
//  cfg     | in  | cfg_valid / cfg_ready   | cfg_gamma (gamma, Q16.16)
//  face    | in  | face_valid / face_ready | face (left and right states)
//  wave    | out | wave_valid / wave_ready | wave (speed_min, speed_max, fault)
//
//  One face state per cycle sustained while the skid is empty; a transfer in
//  reaches wave_valid through two 33-stage dividers and a 24-stage square root.
//  Reset clears the valid chain and loads gamma with about 1.4.
//  A stalled output parks one result in a skid register; the pipeline then
//  holds as a whole until the skid empties, losing and repeating nothing.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module hlle_wave_speed_estimate (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hwse_pkg::GAMMA_W-1:0]   cfg_gamma,
    input  logic                           face_valid,
    output logic                           face_ready,
    input  hwse_pkg::face_t                face,
    output logic                           wave_valid,
    input  logic                           wave_ready,
    output hwse_pkg::wave_t                wave
);
    import hwse_pkg::*;

    localparam int B_LEN     = DIV_LAT + ROOT_W;
    localparam int PIPE_LAST = 2 * DIV_LAT + ROOT_W + 9;

    typedef struct packed {
        logic signed [31:0] rho_l;
        logic signed [31:0] rho_r;
        logic signed [31:0] en_l;
        logic signed [31:0] en_r;
        logic               fault;
    } side_t;

    typedef struct packed {
        logic signed [31:0] rho_l;
        logic signed [31:0] rho_r;
        logic signed [31:0] en_l;
        logic signed [31:0] en_r;
        logic signed [31:0] ul;
        logic signed [31:0] ur;
        logic signed [31:0] ua;
        logic               fault;
    } mid_t;

    typedef struct packed {
        logic signed [31:0] ul;
        logic signed [31:0] ur;
        logic signed [31:0] ua;
        logic               fault;
    } tail_t;

    logic [GAMMA_W-1:0] gamma_reg;
    logic               en;
    logic               push;
    logic [PIPE_LAST:0] vld_reg;

    face_t              in_reg;
    logic               in_fault_reg;
    side_t              sa_reg [0:DIV_LAT-1];

    logic signed [VEL_NUM_W-1:0] vel_num [0:5];
    logic [31:0]                 vel_den [0:5];
    logic signed [31:0]          vel_q   [0:5];

    mid_t               m1_reg, m2_reg, m3_reg, m4_reg, m5_reg, m6_reg;
    logic [46:0]        sq_reg    [0:5];
    logic [30:0]        sumsq_reg [0:1];
    logic [30:0]        kin_reg   [0:1];
    logic signed [31:0] inner_reg [0:1];
    logic signed [31:0] p_reg     [0:1];
    logic signed [31:0] pl_reg, pr_reg, pa_reg;
    logic [31:0]        ra_reg;

    logic signed [SND_NUM_W-1:0] snd_num_reg [0:2];
    logic [31:0]                 snd_den_reg [0:2];
    logic [QUOT_W-1:0]           snd_mag     [0:2];
    logic signed [31:0]          snd_q       [0:2];
    logic [ROOT_W-1:0]           snd_c       [0:2];
    tail_t                       tb_reg      [0:B_LEN];

    logic signed [31:0] lo_a_reg, lo_b_reg, hi_a_reg, hi_b_reg;
    logic               f1_fault_reg;
    wave_t              res_reg;

    wave_t              wave_reg;
    logic               wave_valid_reg;
    wave_t              sk_reg;
    logic               sk_valid_reg;

    // combinational next values
    logic signed [63:0] sq_prod_next [0:5];
    logic signed [32:0] ua_sum_next;
    logic [48:0]        sumsq_sum_next [0:1];
    logic [61:0]        kin_prod_next  [0:1];
    logic signed [20:0] gm1_next;
    logic signed [52:0] p_prod_next    [0:1];
    logic signed [32:0] pa_sum_next;
    logic [32:0]        ra_sum_next;
    logic signed [SND_NUM_W-1:0] gp_next [0:2];

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg <= GAMMA_RESET;
        end
        else if (cfg_valid)
        begin
            gamma_reg <= cfg_gamma;
        end
    end

    // ------------------------------------------------------------------
    // flow control: the whole pipe advances while the skid is empty
    // ------------------------------------------------------------------
    assign en         = !sk_valid_reg;
    assign face_ready = en;
    assign push       = en && vld_reg[PIPE_LAST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PIPE_LAST-1:0], face_valid};
        end
    end

    // ------------------------------------------------------------------
    // input stage and velocity division
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_reg       <= face;
            in_fault_reg <= (face.rho_left <= 32'sd0) || (face.rho_right <= 32'sd0);
        end
    end

    assign vel_num[0] = $signed({in_reg.mom_x_left,  16'h0000});
    assign vel_num[1] = $signed({in_reg.mom_y_left,  16'h0000});
    assign vel_num[2] = $signed({in_reg.mom_z_left,  16'h0000});
    assign vel_num[3] = $signed({in_reg.mom_x_right, 16'h0000});
    assign vel_num[4] = $signed({in_reg.mom_y_right, 16'h0000});
    assign vel_num[5] = $signed({in_reg.mom_z_right, 16'h0000});
    assign vel_den[0] = in_reg.rho_left;
    assign vel_den[1] = in_reg.rho_left;
    assign vel_den[2] = in_reg.rho_left;
    assign vel_den[3] = in_reg.rho_right;
    assign vel_den[4] = in_reg.rho_right;
    assign vel_den[5] = in_reg.rho_right;

    for (genvar i = 0; i < 6; i++)
    begin : g_vel
        hwse_div #(
            .NUM_W (VEL_NUM_W)
        ) u_div (
            .clk  (clk),
            .en   (en),
            .num  (vel_num[i]),
            .den  (vel_den[i]),
            .quot (vel_q[i]),
            .mag  ()
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa_reg[0] <= '{rho_l: in_reg.rho_left, rho_r: in_reg.rho_right,
                           en_l: in_reg.energy_left, en_r: in_reg.energy_right,
                           fault: in_fault_reg};
            for (int k = 1; k < DIV_LAT; k++)
            begin
                sa_reg[k] <= sa_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // pressure: squares, sum, kinetic energy, internal energy, pressure
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            sq_prod_next[i] = vel_q[i] * vel_q[i];
        end
        ua_sum_next = 33'(vel_q[0]) + 33'(vel_q[3]);
        for (int s = 0; s < 2; s++)
        begin
            sumsq_sum_next[s] = 49'(sq_reg[3*s]) + 49'(sq_reg[3*s+1]) + 49'(sq_reg[3*s+2]);
        end
        kin_prod_next[0] = 62'(m2_reg.rho_l[30:0]) * 62'(sumsq_reg[0]);
        kin_prod_next[1] = 62'(m2_reg.rho_r[30:0]) * 62'(sumsq_reg[1]);
        gm1_next = $signed({2'b00, gamma_reg}) - 21'sd65536;
        for (int s = 0; s < 2; s++)
        begin
            p_prod_next[s] = gm1_next * inner_reg[s];
        end
        pa_sum_next = 33'(p_reg[0]) + 33'(p_reg[1]);
        ra_sum_next = 33'(m5_reg.rho_l) + 33'(m5_reg.rho_r);
        gp_next[0] = $signed({1'b0, gamma_reg}) * pl_reg;
        gp_next[1] = $signed({1'b0, gamma_reg}) * pr_reg;
        gp_next[2] = $signed({1'b0, gamma_reg}) * pa_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg <= '{rho_l: sa_reg[DIV_LAT-1].rho_l, rho_r: sa_reg[DIV_LAT-1].rho_r,
                        en_l: sa_reg[DIV_LAT-1].en_l, en_r: sa_reg[DIV_LAT-1].en_r,
                        ul: vel_q[0], ur: vel_q[3], ua: ua_sum_next[32:1],
                        fault: sa_reg[DIV_LAT-1].fault};
            for (int i = 0; i < 6; i++)
            begin
                sq_reg[i] <= sq_prod_next[i][62:16];
            end

            m2_reg <= m1_reg;
            for (int s = 0; s < 2; s++)
            begin
                sumsq_reg[s] <= (|sumsq_sum_next[s][48:31]) ? 31'h7FFF_FFFF
                                                             : sumsq_sum_next[s][30:0];
            end

            m3_reg <= m2_reg;
            for (int s = 0; s < 2; s++)
            begin
                kin_reg[s] <= (|kin_prod_next[s][61:48]) ? 31'h7FFF_FFFF
                                                          : kin_prod_next[s][47:17];
            end

            m4_reg <= m3_reg;
            inner_reg[0] <= sat32(64'(m3_reg.en_l) - 64'($signed({1'b0, kin_reg[0]})));
            inner_reg[1] <= sat32(64'(m3_reg.en_r) - 64'($signed({1'b0, kin_reg[1]})));

            m5_reg <= m4_reg;
            for (int s = 0; s < 2; s++)
            begin
                p_reg[s] <= sat32(64'(p_prod_next[s] >>> 16));
            end

            // arithmetic averages; both densities are positive when they matter
            m6_reg <= m5_reg;
            pl_reg <= p_reg[0];
            pr_reg <= p_reg[1];
            pa_reg <= pa_sum_next[32:1];
            ra_reg <= ra_sum_next[32:1];

            snd_num_reg[0] <= gp_next[0];
            snd_num_reg[1] <= gp_next[1];
            snd_num_reg[2] <= gp_next[2];
            snd_den_reg[0] <= m6_reg.rho_l;
            snd_den_reg[1] <= m6_reg.rho_r;
            snd_den_reg[2] <= ra_reg;
            tb_reg[0] <= '{ul: m6_reg.ul, ur: m6_reg.ur, ua: m6_reg.ua, fault: m6_reg.fault};
            for (int k = 1; k <= B_LEN; k++)
            begin
                tb_reg[k] <= tb_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // sound speeds: |gamma p / rho|, then square root
    // ------------------------------------------------------------------
    for (genvar i = 0; i < 3; i++)
    begin : g_snd
        hwse_div #(
            .NUM_W (SND_NUM_W)
        ) u_div (
            .clk  (clk),
            .en   (en),
            .num  (snd_num_reg[i]),
            .den  (snd_den_reg[i]),
            .quot (snd_q[i]),
            .mag  (snd_mag[i])
        );

        hwse_isqrt #(
            .ROOT_W (ROOT_W)
        ) u_isqrt (
            .clk  (clk),
            .en   (en),
            .rad  ({1'b0, snd_mag[i], 16'h0000}),
            .root (snd_c[i])
        );
    end

    // ------------------------------------------------------------------
    // speed bounds
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_a_reg <= sat32(64'(tb_reg[B_LEN].ul) - 64'($signed({1'b0, snd_c[0]})));
            lo_b_reg <= sat32(64'(tb_reg[B_LEN].ua) - 64'($signed({1'b0, snd_c[2]})));
            hi_a_reg <= sat32(64'(tb_reg[B_LEN].ur) + 64'($signed({1'b0, snd_c[1]})));
            hi_b_reg <= sat32(64'(tb_reg[B_LEN].ua) + 64'($signed({1'b0, snd_c[2]})));
            f1_fault_reg <= tb_reg[B_LEN].fault;

            if (f1_fault_reg)
            begin
                res_reg <= '{speed_min: 32'sd0, speed_max: 32'sd0, density_fault: 1'b1};
            end
            else
            begin
                res_reg <= '{speed_min: (lo_a_reg < lo_b_reg) ? lo_a_reg : lo_b_reg,
                             speed_max: (hi_a_reg > hi_b_reg) ? hi_a_reg : hi_b_reg,
                             density_fault: 1'b0};
            end
        end
    end

    // ------------------------------------------------------------------
    // output register with skid
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_valid_reg <= 1'b0;
            sk_valid_reg   <= 1'b0;
        end
        else if (wave_valid_reg && !wave_ready)
        begin
            // hold the output, park an arriving result
            if (push)
            begin
                sk_valid_reg <= 1'b1;
            end
        end
        else if (sk_valid_reg)
        begin
            wave_valid_reg <= 1'b1;
            sk_valid_reg   <= 1'b0;
        end
        else
        begin
            wave_valid_reg <= push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wave_valid_reg && !wave_ready)
        begin
            if (push)
            begin
                sk_reg <= res_reg;
            end
        end
        else if (sk_valid_reg)
        begin
            wave_reg <= sk_reg;
        end
        else
        begin
            wave_reg <= res_reg;
        end
    end

    assign wave_valid = wave_valid_reg;
    assign wave       = wave_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `CHECK_IMPLY(a_fault_zero, wave_valid && wave.density_fault, wave.speed_min == 32'sd0 && wave.speed_max == 32'sd0, "density fault with nonzero speeds")
    `CHECK_IMPLY(a_speed_order, wave_valid, wave.speed_min <= wave.speed_max, "speed_min above speed_max")
    `CHECK_IMPLY(a_skid_behind, sk_valid_reg, wave_valid, "skid holds data with empty output")
    `CHECK_NEXT(a_skid_drain, sk_valid_reg && wave_ready, wave_valid && !sk_valid_reg, "skid did not drain on transfer")

endmodule

`default_nettype wire

// ----- src/hwse_div.sv -----
// ----------------------------------------------------------------------------
// hwse_div
// Pipelined signed restoring divider, one quotient bit per stage, with
// quotient saturated to signed 32 bits and truncation toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module hwse_div #(
    parameter int NUM_W = hwse_pkg::VEL_NUM_W
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [NUM_W-1:0] num,
    input  logic [31:0]             den,
    output logic signed [31:0]      quot,
    output logic [hwse_pkg::QUOT_W-1:0] mag
);
    import hwse_pkg::*;

    localparam int HI_W = NUM_W - QUOT_W;

    logic [NUM_W-1:0] num_abs;
    logic             ovf;

    logic [31:0]       rem_reg [0:QUOT_W];
    logic [QUOT_W-1:0] low_reg [0:QUOT_W];
    logic [QUOT_W-1:0] q_reg   [0:QUOT_W];
    logic [31:0]       den_reg [0:QUOT_W];
    logic              neg_reg [0:QUOT_W];
    logic              ovf_reg [0:QUOT_W];

    logic signed [31:0]  quot_reg;
    logic [QUOT_W-1:0]   mag_reg;

    assign num_abs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    // a quotient of 2^31 or more only needs the high part against the divisor
    assign ovf = ({{(32-HI_W){1'b0}}, num_abs[NUM_W-1:QUOT_W]} >= den);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= ovf ? 32'd0 : {{(32-HI_W){1'b0}}, num_abs[NUM_W-1:QUOT_W]};
            low_reg[0] <= num_abs[QUOT_W-1:0];
            q_reg[0]   <= '0;
            den_reg[0] <= den;
            neg_reg[0] <= num[NUM_W-1];
            ovf_reg[0] <= ovf;
        end
    end

    for (genvar j = 1; j <= QUOT_W; j++)
    begin : g_step
        logic [32:0] trial;
        logic        take;

        assign trial = {rem_reg[j-1], low_reg[j-1][QUOT_W-1]};
        assign take  = (trial >= {1'b0, den_reg[j-1]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= take ? 32'(trial - {1'b0, den_reg[j-1]}) : trial[31:0];
                low_reg[j] <= {low_reg[j-1][QUOT_W-2:0], 1'b0};
                q_reg[j]   <= {q_reg[j-1][QUOT_W-2:0], take};
                den_reg[j] <= den_reg[j-1];
                neg_reg[j] <= neg_reg[j-1];
                ovf_reg[j] <= ovf_reg[j-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (ovf_reg[QUOT_W])
            begin
                quot_reg <= neg_reg[QUOT_W] ? S32_MIN : S32_MAX;
                mag_reg  <= '1;
            end
            else
            begin
                quot_reg <= neg_reg[QUOT_W] ? -$signed({1'b0, q_reg[QUOT_W]})
                                            : $signed({1'b0, q_reg[QUOT_W]});
                mag_reg  <= q_reg[QUOT_W];
            end
        end
    end

    assign quot = quot_reg;
    assign mag  = mag_reg;

endmodule

`default_nettype wire

// ----- src/hwse_isqrt.sv -----
// ----------------------------------------------------------------------------
// hwse_isqrt
// Pipelined integer square root, one root bit per stage, floor result.
// ----------------------------------------------------------------------------
`default_nettype none

module hwse_isqrt #(
    parameter int ROOT_W = hwse_pkg::ROOT_W
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [2*ROOT_W-1:0]   rad,
    output logic [ROOT_W-1:0]     root
);
    import hwse_pkg::*;

    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 3;

    logic [REM_W-1:0]  rem_reg [0:ROOT_W-1];
    logic [ROOT_W-1:0] res_reg [0:ROOT_W-1];
    logic [RAD_W-1:0]  rad_reg [0:ROOT_W-1];

    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_step
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] res_in;
        logic [RAD_W-1:0]  rad_in;
        logic [REM_W-1:0]  cur;
        logic [REM_W-1:0]  trial;
        logic              take;

        if (j == 0)
        begin : g_first
            assign rem_in = '0;
            assign res_in = '0;
            assign rad_in = rad;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[j-1];
            assign res_in = res_reg[j-1];
            assign rad_in = rad_reg[j-1];
        end

        // bring down the next pair of radicand bits
        assign cur   = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
        assign trial = REM_W'({res_in, 2'b01});
        assign take  = (cur >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= take ? cur - trial : cur;
                res_reg[j] <= {res_in[ROOT_W-2:0], take};
                rad_reg[j] <= {rad_in[RAD_W-3:0], 2'b00};
            end
        end
    end

    assign root = res_reg[ROOT_W-1];

endmodule

`default_nettype wire

// ----- sim/tb_hlle_wave_speed_estimate.sv -----
// ----------------------------------------------------------------------------
// tb_hlle_wave_speed_estimate
// Streams face states through the HLLE speed estimator and checks every wave
// result against an in-bench fixed-point predictor, under several gamma
// settings, idle/stall mixes and a long output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_hlle_wave_speed_estimate;

    import hwse_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 150;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [GAMMA_W-1:0]    cfg_gamma;
    logic                  face_valid;
    logic                  face_ready;
    face_t                 face;
    logic                  wave_valid;
    logic                  wave_ready;
    wave_t                 wave;

    logic [GAMMA_W-1:0]    gamma_now;
    wave_t                 pending_waves[$];
    int                    errors;
    int                    idle_pct;
    int                    stall_pct;
    logic                  hold_off;
    int                    quiet_cycles;

    hlle_wave_speed_estimate i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_gamma  (cfg_gamma),
        .face_valid (face_valid),
        .face_ready (face_ready),
        .face       (face),
        .wave_valid (wave_valid),
        .wave_ready (wave_ready),
        .wave       (wave)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ---------------- fixed-point predictor ----------------

    function automatic longint clamp_s32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint int_root(input longint n);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > n)
        begin
            b = b >>> 2;
        end
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >>> 1) + b;
            end
            else
            begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic longint flow_speed(input longint mom, input longint rho);
        return clamp_s32((mom * 65536) / rho);
    endfunction

    function automatic longint gas_pressure(input longint rho, input longint u1,
                                            input longint u2, input longint u3,
                                            input longint e, input longint g);
        longint sumsq;
        longint kin;
        longint inner;
        sumsq = clamp_s32(((u1 * u1) >>> 16) + ((u2 * u2) >>> 16) + ((u3 * u3) >>> 16));
        kin   = clamp_s32((rho * sumsq) >>> 17);
        inner = clamp_s32(e - kin);
        return clamp_s32(((g - 65536) * inner) >>> 16);
    endfunction

    function automatic longint sound_speed(input longint g, input longint p,
                                           input longint rho);
        longint t;
        t = (g * p) / rho;
        if (t < 0)
        begin
            t = -t;
        end
        t = clamp_s32(t);
        return int_root(t <<< 16);
    endfunction

    function automatic wave_t predict_wave(input face_t f, input logic [GAMMA_W-1:0] gw);
        wave_t  w;
        longint g, rl, rr, ul1, ur1, pl, pr, ra, ua, pa, cl, cr, ca, a, b;
        g  = longint'(gw);
        rl = longint'(f.rho_left);
        rr = longint'(f.rho_right);
        w  = '0;
        if (rl <= 0 || rr <= 0)
        begin
            w.density_fault = 1'b1;
            return w;
        end
        ul1 = flow_speed(longint'(f.mom_x_left), rl);
        pl  = gas_pressure(rl, ul1, flow_speed(longint'(f.mom_y_left), rl),
                           flow_speed(longint'(f.mom_z_left), rl),
                           longint'(f.energy_left), g);
        ur1 = flow_speed(longint'(f.mom_x_right), rr);
        pr  = gas_pressure(rr, ur1, flow_speed(longint'(f.mom_y_right), rr),
                           flow_speed(longint'(f.mom_z_right), rr),
                           longint'(f.energy_right), g);
        ra = (rl + rr) >>> 1;
        if (ra < 1)
        begin
            ra = 1;
        end
        ua = (ul1 + ur1) >>> 1;
        pa = (pl + pr) >>> 1;
        cl = sound_speed(g, pl, rl);
        cr = sound_speed(g, pr, rr);
        ca = sound_speed(g, pa, ra);
        a = clamp_s32(ul1 - cl);
        b = clamp_s32(ua - ca);
        w.speed_min = 32'((a < b) ? a : b);
        a = clamp_s32(ur1 + cr);
        b = clamp_s32(ua + ca);
        w.speed_max = 32'((a > b) ? a : b);
        return w;
    endfunction

    // ---------------- output side ----------------

    always @(posedge clk)
    begin
        wave_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        wave_t exp_w;
        if (rst_n && wave_valid && wave_ready)
        begin
            if (pending_waves.size() == 0)
            begin
                $display("%0t: unexpected wave result %h", $time, wave);
                errors++;
            end
            else
            begin
                exp_w = pending_waves.pop_front();
                if (wave.speed_min !== exp_w.speed_min)
                begin
                    $display("%0t: speed_min expected %h actual %h",
                             $time, exp_w.speed_min, wave.speed_min);
                    errors++;
                end
                if (wave.speed_max !== exp_w.speed_max)
                begin
                    $display("%0t: speed_max expected %h actual %h",
                             $time, exp_w.speed_max, wave.speed_max);
                    errors++;
                end
                if (wave.density_fault !== exp_w.density_fault)
                begin
                    $display("%0t: density_fault expected %b actual %b",
                             $time, exp_w.density_fault, wave.density_fault);
                    errors++;
                end
            end
        end
    end

    // count cycles with no transfer on any channel
    always @(posedge clk)
    begin
        if ((face_valid && face_ready) || (wave_valid && wave_ready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("** hlle_wave_speed_estimate: FAILED **");
                $finish;
            end
        end
    end

    // ---------------- stimulus ----------------

    task automatic send_face(input face_t f);
        if ($urandom_range(99) < idle_pct)
        begin
            face_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
            begin
                @(posedge clk);
            end
        end
        face_valid <= 1'b1;
        face       <= f;
        @(posedge clk);
        while (!face_ready)
        begin
            @(posedge clk);
        end
        pending_waves.push_back(predict_wave(f, gamma_now));
    endtask

    task automatic drain_waves();
        face_valid <= 1'b0;
        while (pending_waves.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_gamma(input logic [GAMMA_W-1:0] g);
        drain_waves();
        cfg_valid <= 1'b1;
        cfg_gamma <= g;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        gamma_now = g;
    endtask

    function automatic logic signed [31:0] span_rand(input int bits);
        return $signed($urandom_range((1 << bits) - 1)) - (1 <<< (bits - 1));
    endfunction

    // mostly physical states with random content, some raw noise
    function automatic face_t rand_face();
        face_t f;
        int    pick;
        pick = $urandom_range(99);
        if (pick < 15)
        begin
            f = {$urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom, $urandom};
        end
        else
        begin
            f.rho_left     = $urandom_range(32'h0010_0000, 1);
            f.rho_right    = $urandom_range(32'h0010_0000, 1);
            f.mom_x_left   = span_rand(23);
            f.mom_y_left   = span_rand(21);
            f.mom_z_left   = span_rand(21);
            f.mom_x_right  = span_rand(23);
            f.mom_y_right  = span_rand(21);
            f.mom_z_right  = span_rand(21);
            f.energy_left  = $urandom_range(32'h0100_0000, 0);
            f.energy_right = $urandom_range(32'h0100_0000, 0);
            if (pick < 20)
            begin
                f.energy_left = -f.energy_left;
            end
            else if (pick < 24)
            begin
                f.rho_right = -$signed($urandom_range(4, 0));
            end
            else if (pick < 30)
            begin
                f.rho_left  = $urandom_range(40, 1);
            end
        end
        return f;
    endfunction

    task automatic test_directed();
        face_t f;
        f = '{32'h0001_0000, 32'h0000_8000, 0, 0, 32'h0002_0000,
              32'h0001_0000, -32'sh0000_8000, 0, 0, 32'h0002_0000};
        send_face(f);
        f.rho_left = 0;
        send_face(f);
        f.rho_left = 32'h0001_0000;
        f.rho_right = S32_MIN;
        send_face(f);
        f = {10{S32_MAX}};
        send_face(f);
        f = {S32_MAX, {4{S32_MIN}}, S32_MAX, {4{S32_MIN}}};
        send_face(f);
        f = {32'sd1, S32_MAX, S32_MIN, S32_MAX, S32_MAX,
             32'sd1, S32_MIN, S32_MAX, S32_MIN, S32_MIN};
        send_face(f);
        f = '{32'h0001_0000, 0, 0, 0, 0, 32'h0001_0000, 0, 0, 0, 0};
        send_face(f);
        f.energy_left  = -32'sh0005_0000;
        f.energy_right = -32'sh0000_0001;
        send_face(f);
        f = '{32'h0001_0000, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 32'h0000_1000,
              32'h0000_0100, 32'h0100_0000, 0, 0, 32'h7000_0000};
        send_face(f);
        f = '{32'sd1, 32'sd1, -32'sd1, 0, 32'sd1, 32'sd2, -32'sd1, 32'sd1, 0, -32'sd1};
        send_face(f);
        repeat (10)
        begin
            send_face(rand_face());
        end
    endtask

    task automatic test_idle_mixes();
        int mix[4][2] = '{'{0, 0}, '{54, 0}, '{0, 54}, '{12, 12}};
        for (int k = 0; k < 4; k++)
        begin
            idle_pct  = mix[k][0];
            stall_pct = mix[k][1];
            repeat (60)
            begin
                send_face(rand_face());
            end
        end
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off <= 1'b1;
                repeat (400) @(posedge clk);
                hold_off <= 1'b0;
            end
            repeat (150)
            begin
                send_face(rand_face());
            end
        join
        drain_waves();
    endtask

    task automatic test_gamma_sweep();
        logic [GAMMA_W-1:0] gammas[6] = '{19'd65537, 19'd262144, 19'd0,
                                          19'h7FFFF, 19'd131072, GAMMA_RESET};
        for (int k = 0; k < 6; k++)
        begin
            write_gamma(gammas[k]);
            idle_pct  = $urandom_range(1) ? 12 : 0;
            stall_pct = $urandom_range(1) ? 12 : 0;
            repeat (20)
            begin
                send_face(rand_face());
            end
        end
        write_gamma(19'($urandom_range(262144, 65537)));
        repeat (20)
        begin
            send_face(rand_face());
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_gamma    = '0;
        face_valid   = 1'b0;
        face         = '0;
        wave_ready   = 1'b0;
        hold_off     = 1'b0;
        quiet_cycles = 0;
        errors       = 0;
        idle_pct     = 0;
        stall_pct    = 0;
        gamma_now    = GAMMA_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_idle_mixes();
        test_backpressure();
        test_gamma_sweep();

        drain_waves();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending_waves.size() == 0)
        begin
            $display("** hlle_wave_speed_estimate: PASSED **");
        end
        else
        begin
            $display("** hlle_wave_speed_estimate: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
